### rtl/three_point_angle_top_defines.svh
// Assertion macros used by the checker file.
`ifndef THREE_POINT_ANGLE_TOP_DEFINES_SVH
`define THREE_POINT_ANGLE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TPA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define TPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared constants and types for the three-point angle pipeline.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int unsigned NormBits  = 31;  // signed, magnitude below 2^30
  localparam int unsigned CordIters = 24;
  localparam int unsigned AngBits   = 26;  // signed accumulated angle
  localparam int unsigned CordBits  = 36;  // CORDIC x/y width, signed

  localparam logic [AngBits-1:0] QuarterTurn = AngBits'(9216000);
  localparam logic [AngBits-1:0] HalfTurn    = AngBits'(18432000);
  localparam logic [14:0]        MaxAngle    = 15'd18000;

  // Arctangent table in 1/1024 centidegree.
  function automatic logic [AngBits-1:0] atan_lut(input logic [4:0] idx);
    logic [AngBits-1:0] r;
    unique case (idx)
      5'd0: r = AngBits'(4608000);  5'd1: r = AngBits'(2720261);
      5'd2: r = AngBits'(1437311);  5'd3: r = AngBits'(729602);
      5'd4: r = AngBits'(366217);   5'd5: r = AngBits'(183287);
      5'd6: r = AngBits'(91666);    5'd7: r = AngBits'(45836);
      5'd8: r = AngBits'(22918);    5'd9: r = AngBits'(11459);
      5'd10: r = AngBits'(5730);    5'd11: r = AngBits'(2865);
      5'd12: r = AngBits'(1432);    5'd13: r = AngBits'(716);
      5'd14: r = AngBits'(358);     5'd15: r = AngBits'(179);
      5'd16: r = AngBits'(90);      5'd17: r = AngBits'(45);
      5'd18: r = AngBits'(22);      5'd19: r = AngBits'(11);
      5'd20: r = AngBits'(6);       5'd21: r = AngBits'(3);
      5'd22: r = AngBits'(1);       5'd23: r = AngBits'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Side information that travels down the pipeline with each item.
  typedef struct packed {
    logic degen;
    logic neg_dot;
  } side_t;

endpackage

### rtl/tpa_norm.sv
// ----------------------------------------------------------------------------
// tpa_norm
// Scales one difference vector so its largest magnitude is in [2^29, 2^30).
// Purely combinational; the caller registers the result.
// ----------------------------------------------------------------------------
module tpa_norm
  import tpa_pkg::*;
#(
  parameter int unsigned DiffBits = 25
) (
  input  logic signed [DiffBits-1:0] v0_i,
  input  logic signed [DiffBits-1:0] v1_i,
  input  logic signed [DiffBits-1:0] v2_i,
  output logic signed [NormBits-1:0] n0_o,
  output logic signed [NormBits-1:0] n1_o,
  output logic signed [NormBits-1:0] n2_o,
  output logic                       zero_o
);

  localparam int unsigned WorkBits = DiffBits + 31;

  logic [DiffBits-1:0] m0, m1, m2, mx;
  logic [WorkBits-1:0] u0, u1, u2;
  logic signed [WorkBits-1:0] w0, w1, w2;
  int unsigned msb;

  // Largest magnitude and the position of its top bit.
  always_comb begin
    m0 = v0_i[DiffBits-1] ? DiffBits'(-v0_i) : DiffBits'(v0_i);
    m1 = v1_i[DiffBits-1] ? DiffBits'(-v1_i) : DiffBits'(v1_i);
    m2 = v2_i[DiffBits-1] ? DiffBits'(-v2_i) : DiffBits'(v2_i);
    mx = m0 | m1 | m2;
    if (m1 > m0) mx = m1; else mx = m0;
    if (m2 > mx) mx = m2;
    msb = 0;
    for (int b = 0; b < DiffBits; b++) begin
      if (mx[b]) msb = b;
    end
  end

  // Shift magnitudes so the top bit lands on bit 29; halving truncates toward zero.
  always_comb begin
    u0 = WorkBits'(m0) << 29;
    u1 = WorkBits'(m1) << 29;
    u2 = WorkBits'(m2) << 29;
    u0 = u0 >> msb;
    u1 = u1 >> msb;
    u2 = u2 >> msb;
    w0 = v0_i[DiffBits-1] ? -$signed(u0) : $signed(u0);
    w1 = v1_i[DiffBits-1] ? -$signed(u1) : $signed(u1);
    w2 = v2_i[DiffBits-1] ? -$signed(u2) : $signed(u2);
  end

  assign n0_o   = NormBits'(w0);
  assign n1_o   = NormBits'(w1);
  assign n2_o   = NormBits'(w2);
  assign zero_o = (mx == '0);

endmodule

### rtl/three_point_angle_top.sv
// ----------------------------------------------------------------------------
// three_point_angle_top
// Angle at a vertex from three points: normalize, products, root, CORDIC.
// ----------------------------------------------------------------------------
// Channel  | Direction | tdata fields (low bit first)
// s_axis   | in        | first_xyz, vertex_xyz, third_xyz, COORD_BITS each
// m_axis   | out       | angle_centideg[14:0], degenerate[15]
//
// One item per cycle unless the output stalls. Stages: five front stages, 31
// square-root stages (the last root bit is folded into the CORDIC load), one
// CORDIC load, one stage per CORDIC step (24) and one output stage.
// Reset clears only the valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
module three_point_angle_top
  import tpa_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // first_x, first_y, first_z, vertex_x, vertex_y, vertex_z, third_x, third_y,
  // third_z, zero fill
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // angle_centideg, degenerate
  output logic [15:0]                m_axis_tdata
);

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned SqBits   = 62;
  localparam int unsigned RootSt   = 31;
  localparam int unsigned Stages   = 5 + RootSt + 1 + CordIters + 1;

  logic adv;
  logic [Stages-1:0] vld_q;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Stages-1];

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: differences.
  logic signed [COORD_BITS-1:0] p [9];
  logic signed [DiffBits-1:0] da_q [3], db_q [3];
  always_comb begin
    for (int k = 0; k < 9; k++) p[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        da_q[k] <= DiffBits'(p[k]) - DiffBits'(p[3+k]);
        db_q[k] <= DiffBits'(p[6+k]) - DiffBits'(p[3+k]);
      end
    end
  end

  // Stage 1: normalization.
  logic signed [NormBits-1:0] na [3], nb [3];
  logic za, zb;
  tpa_norm #(.DiffBits(DiffBits)) u_norm_a (
    .v0_i(da_q[0]), .v1_i(da_q[1]), .v2_i(da_q[2]),
    .n0_o(na[0]), .n1_o(na[1]), .n2_o(na[2]), .zero_o(za));
  tpa_norm #(.DiffBits(DiffBits)) u_norm_b (
    .v0_i(db_q[0]), .v1_i(db_q[1]), .v2_i(db_q[2]),
    .n0_o(nb[0]), .n1_o(nb[1]), .n2_o(nb[2]), .zero_o(zb));

  logic signed [NormBits-1:0] a_q [3], b_q [3];
  logic degen1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= na[k];
        b_q[k] <= nb[k];
      end
      degen1_q <= za || zb;
    end
  end

  // Stage 2: the nine products, each 31x31.
  logic signed [61:0] pr_q [9];
  logic degen2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= a_q[0] * b_q[0];
      pr_q[1] <= a_q[1] * b_q[1];
      pr_q[2] <= a_q[2] * b_q[2];
      pr_q[3] <= a_q[1] * b_q[2];
      pr_q[4] <= a_q[2] * b_q[1];
      pr_q[5] <= a_q[2] * b_q[0];
      pr_q[6] <= a_q[0] * b_q[2];
      pr_q[7] <= a_q[0] * b_q[1];
      pr_q[8] <= a_q[1] * b_q[0];
      degen2_q <= degen1_q;
    end
  end

  // Stage 3: dot and cross components, reduced to magnitudes >> 30.
  logic signed [63:0] dotv, cx [3];
  logic [31:0] ct [3];
  logic [31:0] ct_q [3];
  logic [33:0] dx_q;
  side_t side3_q;
  always_comb begin
    dotv  = 64'(pr_q[0]) + 64'(pr_q[1]) + 64'(pr_q[2]);
    cx[0] = 64'(pr_q[3]) - 64'(pr_q[4]);
    cx[1] = 64'(pr_q[5]) - 64'(pr_q[6]);
    cx[2] = 64'(pr_q[7]) - 64'(pr_q[8]);
    for (int k = 0; k < 3; k++) begin
      ct[k] = 32'((cx[k][63] ? -cx[k] : cx[k]) >> 30);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) ct_q[k] <= ct[k];
      dx_q <= 34'((dotv[63] ? -dotv : dotv) >> 30);
      side3_q <= '{degen: degen2_q, neg_dot: dotv[63]};
    end
  end

  // Stage 4: squares, each 32x32, then summed.
  logic [SqBits+1:0] sq_q;
  logic [33:0] dx4_q;
  side_t side4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= (SqBits+2)'(ct_q[0] * ct_q[0]) + (SqBits+2)'(ct_q[1] * ct_q[1])
            + (SqBits+2)'(ct_q[2] * ct_q[2]);
      dx4_q <= dx_q;
      side4_q <= side3_q;
    end
  end

  // Square root: one result bit per step, 32 steps for a 64-bit radicand, the last one unregistered.
  localparam int unsigned RN = 32;
  logic [63:0]   rem_q   [1:RN-1];
  logic [RN-1:0] root_q  [1:RN-1];
  logic [33:0]   rdx_q   [1:RN-1];
  side_t         rside_q [1:RN-1];
  logic [RN-1:0] root_fin;
  logic [33:0]   rdx_fin;
  side_t         rside_fin;
  for (genvar s = 0; s < RN; s++) begin : g_sqrt
    logic [63:0]   rem_in;
    logic [RN-1:0] root_in;
    logic [33:0]   rdx_in;
    side_t         side_in;
    logic [65:0]   trial;
    logic [65:0]   remsh;
    // The first step starts from the radicand with an empty root.
    if (s == 0) begin : g_first
      always_comb begin
        rem_in  = sq_q;
        root_in = '0;
        rdx_in  = dx4_q;
        side_in = side4_q;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem_q[s];
        root_in = root_q[s];
        rdx_in  = rdx_q[s];
        side_in = rside_q[s];
      end
    end
    always_comb begin
      remsh = {2'b00, rem_in};
      trial = 66'({root_in, 2'b01}) << (2*(RN-1-s));
    end
    if (s < RN - 1) begin : g_reg
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (remsh >= trial) begin
            rem_q[s+1]  <= 64'(remsh - trial);
            root_q[s+1] <= RN'({root_in, 1'b1});
          end else begin
            rem_q[s+1]  <= rem_in;
            root_q[s+1] <= RN'({root_in, 1'b0});
          end
          rdx_q[s+1]   <= rdx_in;
          rside_q[s+1] <= side_in;
        end
      end
    end else begin : g_last
      always_comb begin
        root_fin  = (remsh >= trial) ? RN'({root_in, 1'b1}) : RN'({root_in, 1'b0});
        rdx_fin   = rdx_in;
        rside_fin = side_in;
      end
    end
  end

  // CORDIC vectoring: one iteration per stage.
  logic signed [CordBits-1:0] cx_q [CordIters+1], cy_q [CordIters+1];
  logic signed [AngBits-1:0]  cz_q [CordIters+1];
  side_t cside_q [CordIters+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0]    <= CordBits'(rdx_fin);
      cy_q[0]    <= CordBits'(root_fin);
      cz_q[0]    <= '0;
      cside_q[0] <= rside_fin;
    end
  end
  for (genvar i = 0; i < CordIters; i++) begin : g_cordic
    logic signed [CordBits-1:0] sx, sy;
    always_comb begin
      sx = cx_q[i][CordBits-1] ? -CordBits'((-cx_q[i]) >>> i) : (cx_q[i] >>> i);
      sy = cy_q[i][CordBits-1] ? -CordBits'((-cy_q[i]) >>> i) : (cy_q[i] >>> i);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!cy_q[i][CordBits-1]) begin
          cx_q[i+1] <= cx_q[i] + sy;
          cy_q[i+1] <= cy_q[i] - sx;
          cz_q[i+1] <= cz_q[i] + $signed(atan_lut(5'(i)));
        end else begin
          cx_q[i+1] <= cx_q[i] - sy;
          cy_q[i+1] <= cy_q[i] + sx;
          cz_q[i+1] <= cz_q[i] - $signed(atan_lut(5'(i)));
        end
        cside_q[i+1] <= cside_q[i];
      end
    end
  end

  // Final stage: clamp, fold, round.
  logic signed [AngBits-1:0] zc;
  logic [AngBits-1:0] zf;
  logic [AngBits-1:0] zr;
  logic [15:0] out_q;
  always_comb begin
    zc = cz_q[CordIters];
    if (zc[AngBits-1]) zc = '0;
    if ($unsigned(zc) > QuarterTurn) zc = $signed(QuarterTurn);
    zf = cside_q[CordIters].neg_dot ? HalfTurn - $unsigned(zc) : $unsigned(zc);
    zr = (zf + AngBits'(512)) >> 10;
    if (zr > AngBits'(MaxAngle)) zr = AngBits'(MaxAngle);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cside_q[CordIters].degen) out_q <= 16'h8000;
      else out_q <= {1'b0, zr[14:0]};
    end
  end
  assign m_axis_tdata = out_q;

endmodule

### rtl/tpa_checker.sv
// ----------------------------------------------------------------------------
// tpa_checker
// Port-level checks on the three-point angle block.
// ----------------------------------------------------------------------------
`include "three_point_angle_top_defines.svh"
module tpa_checker
  import tpa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // The angle never exceeds a half turn.
  `TPA_ASSERT(a_range, m_axis_tvalid, m_axis_tdata[14:0] <= MaxAngle, "angle out of range")
  // A degenerate result carries a zero angle.
  `TPA_ASSERT(a_degen, m_axis_tvalid && m_axis_tdata[15], m_axis_tdata[14:0] == 15'd0,
    "degenerate result with nonzero angle")
  // Input is taken exactly when the output side can move.
  `TPA_ASSERT(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready),
    "input ready disagrees with output state")
  // A stalled result holds.
  `TPA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
    "stalled result changed")

endmodule

bind three_point_angle_top tpa_checker u_tpa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-point angle pipeline.
// ----------------------------------------------------------------------------
// Point triples go in on the input stream. A local model works out the angle
// at the vertex for each accepted request, and the output stream is checked
// against it in order. Both sides idle at random. One phase holds the output
// off long enough to back up the whole pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import tpa_pkg::*;

  localparam int CB        = 24;
  localparam int DW        = 9 * CB;
  localparam int IdleLimit = 3000;
  localparam int Latency   = 62;

  typedef struct packed {
    logic [14:0] angle;
    logic        degen;
  } angle_res_t;

  localparam longint AtanTab[24] = '{
    4608000, 2720261, 1437311, 729602, 366217, 183287, 91666, 45836,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179,
    90, 45, 22, 11, 6, 3, 1, 1};

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // first_x, first_y, first_z, vertex_x, vertex_y, vertex_z, third_x, third_y,
  // third_z
  logic [DW-1:0] s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // angle_centideg, degenerate
  logic [15:0]   m_axis_tdata;

  angle_res_t angle_q[$];
  bit         no_idle;
  bit         hold_req;
  int         hold_left;
  int         n_sent;
  int         n_checked;
  int         n_degen;
  int         n_errors;
  int         quiet_cycles;

  three_point_angle_top #(.COORD_BITS(CB)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Shift on the magnitude, so negative values truncate toward zero.
  function automatic longint shr_tz(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -longint'(mag(v) >> s);
  endfunction

  // Scale a vector by powers of two until its largest magnitude is in
  // [2^29, 2^30). Returns 0 for the zero vector.
  function automatic bit scale_vec(inout longint v[3]);
    longint unsigned m;
    m = mag(v[0]);
    if (mag(v[1]) > m) m = mag(v[1]);
    if (mag(v[2]) > m) m = mag(v[2]);
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      for (int k = 0; k < 3; k++) v[k] = v[k] / 2;
      m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int k = 0; k < 3; k++) v[k] = v[k] * 2;
      m = m << 1;
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Angle at the vertex via atan2(|cross|, dot) and a vectoring CORDIC.
  function automatic angle_res_t vertex_angle(input logic [DW-1:0] d);
    longint va[3], vb[3], cr[3];
    longint vtx, dot, x, y, z, dx, dy;
    longint unsigned s2, t;
    angle_res_t r;
    for (int k = 0; k < 3; k++) begin
      vtx   = $signed(d[(3+k)*CB +: CB]);
      va[k] = longint'($signed(d[k*CB +: CB])) - vtx;
      vb[k] = longint'($signed(d[(6+k)*CB +: CB])) - vtx;
    end
    if (!scale_vec(va) || !scale_vec(vb)) begin
      r.angle = '0;
      r.degen = 1'b1;
      return r;
    end
    dot   = va[0]*vb[0] + va[1]*vb[1] + va[2]*vb[2];
    cr[0] = va[1]*vb[2] - va[2]*vb[1];
    cr[1] = va[2]*vb[0] - va[0]*vb[2];
    cr[2] = va[0]*vb[1] - va[1]*vb[0];
    s2 = 0;
    for (int k = 0; k < 3; k++) begin
      t  = mag(cr[k]) >> 30;
      s2 = s2 + t * t;
    end
    x = mag(dot) >> 30;
    y = int_sqrt(s2);
    z = 0;
    for (int i = 0; i < 24; i++) begin
      dx = shr_tz(y, i);
      dy = shr_tz(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + AtanTab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - AtanTab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 9216000) z = 9216000;
    if (dot < 0) z = 18432000 - z;
    z = (z + 512) >>> 10;
    if (z > 18000) z = 18000;
    r.angle = z[14:0];
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic logic [DW-1:0] pack_points(input int ax, ay, az, vx, vy, vz,
                                                input int bx, by, bz);
    logic [DW-1:0] d;
    d = {bz[CB-1:0], by[CB-1:0], bx[CB-1:0], vz[CB-1:0], vy[CB-1:0], vx[CB-1:0],
         az[CB-1:0], ay[CB-1:0], ax[CB-1:0]};
    return d;
  endfunction

  function automatic int rand_coord();
    logic [CB-1:0] raw;
    raw = CB'($urandom());
    return $signed(raw);
  endfunction

  // Offer one request, idling at random first, and wait for its acceptance.
  task automatic send_points(input logic [DW-1:0] d);
    while (!no_idle && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Record the expected angle for each accepted request.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      angle_q = {angle_q, vertex_angle(s_axis_tdata)};
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    angle_res_t exp_r;
    int diff;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (angle_q.size() == 0) begin
        $error("result with nothing expected: angle %0d degenerate %0d",
               m_axis_tdata[14:0], m_axis_tdata[15]);
        n_errors++;
      end else begin
        exp_r = angle_q.pop_front();
        if (exp_r.degen) n_degen++;
        diff = int'(exp_r.angle) - int'(m_axis_tdata[14:0]);
        // The angle may be off by one centidegree.
        if (diff > 1 || diff < -1) begin
          $error("angle_centideg mismatch: expected %0d actual %0d",
                 exp_r.angle, m_axis_tdata[14:0]);
          n_errors++;
        end
        if (exp_r.degen !== m_axis_tdata[15]) begin
          $error("degenerate mismatch: expected %0d actual %0d",
                 exp_r.degen, m_axis_tdata[15]);
          n_errors++;
        end
      end
    end
  end

  // Output ready: random idling, or a long counted hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 26);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (angle_q.size() == 0 && !s_axis_tvalid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Extreme coordinates, collinear and perpendicular vectors, tiny vectors.
  task automatic test_extremes();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    send_points(pack_points(mx, mx, mx, mn, mn, mn, mx, mx, mx));
    send_points(pack_points(mx, mx, mx, mn, mn, mn, mn, mn, mx));
    send_points(pack_points(mn, mn, mn, mx, mx, mx, mn, mn, mn));
    send_points(pack_points(mx, 0, 0, mn, 0, 0, mn + 1, 0, 0));
    send_points(pack_points(1, 0, 0, 0, 0, 0, 2, 0, 0));
    send_points(pack_points(1, 0, 0, 0, 0, 0, -1, 0, 0));
    send_points(pack_points(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_points(pack_points(0, 0, 1, 0, 0, 0, 0, -1, 0));
    send_points(pack_points(mx, mx, 0, 0, 0, 0, mn, mx, 0));
    send_points(pack_points(1, 0, 0, 0, 0, 0, 1, 1, 0));
    send_points(pack_points(1000, 0, 0, 0, 0, 0, -1000, 1, 0));
    send_points(pack_points(1000, 0, 0, 0, 0, 0, 1000, 1, 0));
    send_points(pack_points(mx, 1, 0, mn, 0, 0, mx, 0, 1));
    send_points(pack_points(-1, -1, -1, 0, 0, 0, mx, mn, 5));
  endtask

  // Zero-length difference vectors on either side or both.
  task automatic test_zero_vectors();
    send_points(pack_points(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_points(pack_points(5, -7, 9, 5, -7, 9, 1, 2, 3));
    send_points(pack_points(1, 2, 3, -4, 8, 0, -4, 8, 0));
    send_points(pack_points(-8388608, 8388607, 0, -8388608, 8388607, 0,
                            -8388608, 8388607, 0));
  endtask

  // Random triples: full range, short bonds near the vertex, some degenerate.
  task automatic test_random(input int count);
    int vx, vy, vz, sel;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 3 && n < count / 2);
      sel = $urandom_range(99);
      if (sel < 40) begin
        send_points(pack_points(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord()));
      end else if (sel < 92) begin
        vx = $urandom_range(200000) - 100000;
        vy = $urandom_range(200000) - 100000;
        vz = $urandom_range(200000) - 100000;
        send_points(pack_points(vx + $urandom_range(3000) - 1500,
                                vy + $urandom_range(3000) - 1500,
                                vz + $urandom_range(3000) - 1500, vx, vy, vz,
                                vx + $urandom_range(3000) - 1500,
                                vy + $urandom_range(3000) - 1500,
                                vz + $urandom_range(3000) - 1500));
      end else begin
        vx = rand_coord();
        vy = rand_coord();
        vz = rand_coord();
        if (sel[0]) send_points(pack_points(vx, vy, vz, vx, vy, vz,
                                            rand_coord(), rand_coord(), rand_coord()));
        else send_points(pack_points(rand_coord(), rand_coord(), rand_coord(),
                                     vx, vy, vz, vx, vy, vz));
      end
    end
    no_idle = 1'b0;
  endtask

  // Hold the output off while requests keep coming, so the pipeline backs up.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 150; n++)
      send_points(pack_points(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord()));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_degen       = 0;
    n_errors      = 0;
    quiet_cycles  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_zero_vectors();
    test_random(800);
    test_backpressure();
    test_random(650);
    s_axis_tvalid <= 1'b0;

    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 16) @(posedge clk_i);

    $display("Sent %0d point triples and checked %0d angles, %0d of them degenerate,",
             n_sent, n_checked, n_degen);
    $display("with random idling on both sides and one long output stall.");
    if (n_errors == 0 && angle_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
